[hdl/hsv2rgb_pkg.sv]
// Package: pixel word types, conversion constants and shared arithmetic helpers.
`timescale 1ns / 1ps
`default_nettype none
package hsv2rgb_pkg;

  localparam int unsigned HUE_W  = 9;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned PROD_W = 2 * CHAN_W;

  localparam logic [HUE_W-1:0]  SECTOR_DEG = HUE_W'(60);
  localparam logic [CHAN_W-1:0] FULL       = CHAN_W'(255);

  // Hue sectors; hues of 360 and above fold into the magenta sector.
  typedef enum logic [2:0] {
    SEC_RED,
    SEC_YELLOW,
    SEC_GREEN,
    SEC_CYAN,
    SEC_BLUE,
    SEC_MAGENTA
  } sector_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] value;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_out_t;

  // Truncating x / 255 for any 16-bit x below 65535: (x + (x >> 8) + 1) >> 8.
  function automatic logic [CHAN_W:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] sum;
    sum = {1'b0, x} + {{(CHAN_W + 1){1'b0}}, x[PROD_W-1:CHAN_W]} + (PROD_W + 1)'(1);
    return sum[PROD_W:CHAN_W];
  endfunction

  // Gamma 2.0 approximation: (x*x + 255) / 255, saturated to 255.
  function automatic logic [CHAN_W-1:0] gamma_map(input logic [PROD_W-1:0] sq);
    logic [CHAN_W:0] y;
    y = div255(sq + {{CHAN_W{1'b0}}, FULL});
    return y[CHAN_W] ? FULL : y[CHAN_W-1:0];
  endfunction

endpackage
`default_nettype wire

[hdl/hsv_to_rgb_gamma.sv]
// Top level: four-stage pipelined HSV to gamma-corrected RGB converter.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+----------------------------------
//  in_     | input     | in_valid / in_ready  | in_data  (hue, saturation, value)
//  out_    | output    | out_valid / out_ready| out_data (red, green, blue)
//
// One pixel enters per clock while in_ready is high; its result passes the
// stage 1 to 3 registers into the output register. The depth is set by
// the two dependent multiply and divide-by-255 steps (s*f, then
// v*(255 - s*f/255)) plus the gamma square.
// Reset (rst_n, synchronous, active low) clears the stage valid bits only.
// A stall on out_ready holds the stages that are full; empty stages keep
// filling, so bubbles collapse and no word is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module hsv_to_rgb_gamma (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire hsv2rgb_pkg::pix_in_t in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output hsv2rgb_pkg::rgb_out_t    out_data
);

  localparam int unsigned HW = hsv2rgb_pkg::HUE_W;
  localparam int unsigned CW = hsv2rgb_pkg::CHAN_W;
  localparam int unsigned PW = hsv2rgb_pkg::PROD_W;
  localparam int unsigned NTHR = 8;  // sector thresholds 60..480

  // Stage advance: a stage loads when it is empty or its successor moves.
  logic vld1_r, vld2_r, vld3_r, vld4_r;
  logic adv1, adv2, adv3, adv4;

  always_comb begin
    adv4 = !vld4_r || out_ready;
    adv3 = !vld3_r || adv4;
    adv2 = !vld2_r || adv3;
    adv1 = !vld1_r || adv2;
  end

  assign in_ready  = adv1;
  assign out_valid = vld4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      if (adv1) vld1_r <= in_valid;
      if (adv2) vld2_r <= vld1_r;
      if (adv3) vld3_r <= vld2_r;
      if (adv4) vld4_r <= vld3_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: sector and fraction. Count thresholds passed to get hue/60,
  // subtract to get the remainder, then f = rem*255/60 = rem*17/4 exactly.
  // ---------------------------------------------------------------------
  logic [3:0]                 cnt;
  logic [HW-1:0]              rem_full;
  logic [5:0]                 rem;
  logic [9:0]                 rem17;
  hsv2rgb_pkg::sector_t       sec_nxt;
  hsv2rgb_pkg::sector_t       sec1_r;
  logic [CW-1:0]              f1_r, s1_r, v1_r;

  always_comb begin
    cnt = '0;
    for (int k = 1; k <= NTHR; k++) begin
      if (in_data.hue >= HW'(k * 60)) cnt = cnt + 4'd1;
    end
    rem_full = in_data.hue - HW'(cnt * hsv2rgb_pkg::SECTOR_DEG);
    rem      = rem_full[5:0];
    rem17    = {4'b0, rem} + {rem, 4'b0};
    case (cnt)
      4'd0:    sec_nxt = hsv2rgb_pkg::SEC_RED;
      4'd1:    sec_nxt = hsv2rgb_pkg::SEC_YELLOW;
      4'd2:    sec_nxt = hsv2rgb_pkg::SEC_GREEN;
      4'd3:    sec_nxt = hsv2rgb_pkg::SEC_CYAN;
      4'd4:    sec_nxt = hsv2rgb_pkg::SEC_BLUE;
      default: sec_nxt = hsv2rgb_pkg::SEC_MAGENTA;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      sec1_r <= sec_nxt;
      f1_r   <= rem17[9:2];
      s1_r   <= in_data.saturation;
      v1_r   <= in_data.value;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: first products, each divided by 255.
  //   a = s*f/255, b = s*(255-f)/255, p = v*(255-s)/255
  // ---------------------------------------------------------------------
  logic [PW-1:0]              sf, sg, vs;
  logic [CW:0]                a_w, b_w, p_w;
  hsv2rgb_pkg::sector_t       sec2_r;
  logic [CW-1:0]              v2_r, a2_r, b2_r, p2_r;

  always_comb begin
    sf  = PW'(s1_r) * PW'(f1_r);
    sg  = PW'(s1_r) * PW'(hsv2rgb_pkg::FULL - f1_r);
    vs  = PW'(v1_r) * PW'(hsv2rgb_pkg::FULL - s1_r);
    a_w = hsv2rgb_pkg::div255(sf);
    b_w = hsv2rgb_pkg::div255(sg);
    p_w = hsv2rgb_pkg::div255(vs);
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      sec2_r <= sec1_r;
      v2_r   <= v1_r;
      a2_r   <= a_w[CW-1:0];
      b2_r   <= b_w[CW-1:0];
      p2_r   <= p_w[CW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: q = v*(255-a)/255, t = v*(255-b)/255, then pick the channel
  // permutation for the sector.
  // ---------------------------------------------------------------------
  logic [PW-1:0]              vq, vt;
  logic [CW:0]                q_w, t_w;
  logic [CW-1:0]              q, t, p, v;
  hsv2rgb_pkg::rgb_out_t      lin_nxt, lin3_r;

  always_comb begin
    vq = PW'(v2_r) * PW'(hsv2rgb_pkg::FULL - a2_r);
    vt = PW'(v2_r) * PW'(hsv2rgb_pkg::FULL - b2_r);
    q_w = hsv2rgb_pkg::div255(vq);
    t_w = hsv2rgb_pkg::div255(vt);
    q = q_w[CW-1:0];
    t = t_w[CW-1:0];
    p = p2_r;
    v = v2_r;
    case (sec2_r)
      hsv2rgb_pkg::SEC_RED:    lin_nxt = '{red: v, green: t, blue: p};
      hsv2rgb_pkg::SEC_YELLOW: lin_nxt = '{red: q, green: v, blue: p};
      hsv2rgb_pkg::SEC_GREEN:  lin_nxt = '{red: p, green: v, blue: t};
      hsv2rgb_pkg::SEC_CYAN:   lin_nxt = '{red: p, green: q, blue: v};
      hsv2rgb_pkg::SEC_BLUE:   lin_nxt = '{red: t, green: p, blue: v};
      default:                 lin_nxt = '{red: v, green: p, blue: q};
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv3) lin3_r <= lin_nxt;
  end

  // ---------------------------------------------------------------------
  // Stage 4: gamma square, divide and saturate into the output register.
  // ---------------------------------------------------------------------
  logic [PW-1:0]              sq_r, sq_g, sq_b;
  hsv2rgb_pkg::rgb_out_t      out_nxt, out_r;

  always_comb begin
    sq_r = PW'(lin3_r.red)   * PW'(lin3_r.red);
    sq_g = PW'(lin3_r.green) * PW'(lin3_r.green);
    sq_b = PW'(lin3_r.blue)  * PW'(lin3_r.blue);
    out_nxt.red   = hsv2rgb_pkg::gamma_map(sq_r);
    out_nxt.green = hsv2rgb_pkg::gamma_map(sq_g);
    out_nxt.blue  = hsv2rgb_pkg::gamma_map(sq_b);
  end

  always_ff @(posedge clk) begin
    if (adv4) out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

[bench/tb_hsv_to_rgb_gamma.sv]
// Self-checking testbench for the pipelined HSV to gamma-corrected RGB converter.
`timescale 1ns / 1ps
module tb_hsv_to_rgb_gamma;

  localparam int unsigned SPAN           = hsv2rgb_pkg::SECTOR_DEG;  // degrees per hue sector
  localparam int unsigned TOP            = hsv2rgb_pkg::FULL;        // full-scale channel level
  localparam int unsigned CW             = hsv2rgb_pkg::CHAN_W;
  localparam int unsigned HW             = hsv2rgb_pkg::HUE_W;
  localparam int          RANDOM_PIXELS  = 1250;
  localparam int          BACKPRESSURE_AT = 300;        // random word that starts the long hold
  localparam int          DRAIN_AT       = 600;         // random word that waits for a drain
  localparam int          STEADY_FROM    = 800;         // window with no idling on either side
  localparam int          STEADY_TO      = 950;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          TAIL_CYCLES    = 12;          // pipeline is four deep; leave margin
  localparam int          WATCHDOG_LIMIT = 2000;

  typedef struct {
    hsv2rgb_pkg::pix_in_t  px;
    hsv2rgb_pkg::rgb_out_t rgb;
  } pixel_check_t;

  typedef struct {
    hsv2rgb_pkg::pix_in_t  px;
    bit                    typed;   // expected word written in the table
    hsv2rgb_pkg::rgb_out_t rgb;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  hsv2rgb_pkg::pix_in_t  in_data;
  logic                  out_valid;
  logic                  out_ready;
  hsv2rgb_pkg::rgb_out_t out_data;

  wire in_fire  = in_valid && in_ready;
  wire out_fire = out_valid && out_ready;

  pixel_check_t rgb_due[$];   // expected words, oldest first
  plan_row_t    plan[$];      // directed stimulus table

  int  errors;
  int  pixels_sent;
  int  pixels_checked;
  int  wide_hues;             // words with hue of 360 and above
  bit  hold_req;              // ask the receiver for one long hold
  bit  steady;                // no idling on either side while set

  hsv_to_rgb_gamma uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // Gamma 2.0 approximation, saturated at full scale.
  function automatic logic [CW-1:0] gamma_level(input int unsigned x);
    int unsigned y;
    y = (x * x + TOP) / TOP;
    return CW'((y > TOP) ? TOP : y);
  endfunction

  // Expected RGB for one pixel: pick the sector, form p, q and t with
  // truncating division, permute, then gamma-correct each channel.
  function automatic hsv2rgb_pkg::rgb_out_t predict_rgb(input hsv2rgb_pkg::pix_in_t px);
    int unsigned           h, s, v, frac, p, q, t, r, g, b;
    hsv2rgb_pkg::sector_t  sec;
    hsv2rgb_pkg::rgb_out_t res;
    h    = px.hue;
    s    = px.saturation;
    v    = px.value;
    // Hues of 360 and above fall into the magenta sector.
    sec  = (h / SPAN >= 5) ? hsv2rgb_pkg::SEC_MAGENTA : hsv2rgb_pkg::sector_t'(h / SPAN);
    frac = (h % SPAN) * TOP / SPAN;
    p    = v * (TOP - s) / TOP;
    q    = v * (TOP - s * frac / TOP) / TOP;
    t    = v * (TOP - s * (TOP - frac) / TOP) / TOP;
    case (sec)
      hsv2rgb_pkg::SEC_RED: begin
        r = v; g = t; b = p;
      end
      hsv2rgb_pkg::SEC_YELLOW: begin
        r = q; g = v; b = p;
      end
      hsv2rgb_pkg::SEC_GREEN: begin
        r = p; g = v; b = t;
      end
      hsv2rgb_pkg::SEC_CYAN: begin
        r = p; g = q; b = v;
      end
      hsv2rgb_pkg::SEC_BLUE: begin
        r = t; g = p; b = v;
      end
      default: begin
        r = v; g = p; b = q;
      end
    endcase
    res.red   = gamma_level(r);
    res.green = gamma_level(g);
    res.blue  = gamma_level(b);
    return res;
  endfunction

  // Channel level with extra weight on the ends of the range.
  function automatic logic [CW-1:0] pick_level();
    logic [CW-1:0] ends [4];
    ends = '{8'd0, 8'd1, 8'd254, 8'd255};
    if ($urandom_range(0, 5) == 0) return ends[$urandom_range(0, 3)];
    return CW'($urandom);
  endfunction

  function automatic hsv2rgb_pkg::pix_in_t pick_pixel();
    hsv2rgb_pkg::pix_in_t px;
    int unsigned          pick;
    pick = $urandom_range(0, 9);
    if (pick == 0)      px.hue = HW'($urandom_range(360, 511));
    else if (pick == 1) px.hue = HW'($urandom);
    else                px.hue = HW'($urandom_range(0, 359));
    px.saturation = pick_level();
    px.value      = pick_level();
    return px;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_row(input int h, input int s, input int v, input bit typed,
                                  input int r = 0, input int g = 0, input int b = 0);
    plan_row_t row;
    row.px.hue        = HW'(h);
    row.px.saturation = CW'(s);
    row.px.value      = CW'(v);
    row.typed         = typed;
    row.rgb.red       = CW'(r);
    row.rgb.green     = CW'(g);
    row.rgb.blue      = CW'(b);
    plan.push_back(row);
  endfunction

  // Offer one word after an idle gap and hold it until accepted; record
  // the expected word at the accepting edge. Valid stays high afterwards,
  // so back-to-back words need no drop and re-raise in one step.
  task automatic send_pixel(input hsv2rgb_pkg::pix_in_t px, input int gap, input bit typed,
                            input hsv2rgb_pkg::rgb_out_t typed_rgb);
    pixel_check_t due;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
    due.px  = px;
    due.rgb = typed ? typed_rgb : predict_rgb(px);
    rgb_due.push_back(due);
    pixels_sent++;
    if (px.hue > 359) wide_hues++;
  endtask

  // Drop valid and wait until every expected word has come out.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (rgb_due.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input pixel_check_t due);
    errors++;
    if (errors <= 10)
      $display("%0t: %s: pixel h=%0d s=%0d v=%0d expected rgb=%0d,%0d,%0d got %0d,%0d,%0d",
               $realtime, what, due.px.hue, due.px.saturation, due.px.value,
               due.rgb.red, due.rgb.green, due.rgb.blue,
               out_data.red, out_data.green, out_data.blue);
  endtask

  // Result checker: compare every accepted output word with the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    pixel_check_t due;
    if (rst_n && out_fire) begin
      if (rgb_due.size() == 0) begin
        due = '{px: '0, rgb: 'x};
        note_mismatch("output word with nothing expected", due);
      end else begin
        due = rgb_due.pop_front();
        pixels_checked++;
        if (out_data.red !== due.rgb.red || out_data.green !== due.rgb.green ||
            out_data.blue !== due.rgb.blue)
          note_mismatch("rgb mismatch", due);
      end
    end
  end

  // Receiver: random ready pattern, one long hold on request, and
  // constant ready inside the steady window.
  initial begin : receiver
    int run;
    out_ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        run       = HOLD_CYCLES;
        hold_req  = 1'b0;
      end else if (steady || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        run       = steady ? 1 : $urandom_range(1, 8);
      end else begin
        out_ready <= 1'b0;
        run       = pick_gap();
        if (run == 0) run = 1;
      end
      repeat (run) @(posedge clk);
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || in_fire || out_fire) quiet = 0;
      else quiet++;
    end
    $display("tb_hsv_to_rgb_gamma: done, errors");
    $finish;
  end

  initial begin : stimulus
    hsv2rgb_pkg::rgb_out_t none;
    int                    gap;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    errors         = 0;
    pixels_sent    = 0;
    pixels_checked = 0;
    wide_hues      = 0;
    hold_req       = 1'b0;
    steady         = 1'b0;
    none           = '0;

    // Black comes out as 1 on every channel; full scale saturates at 255.
    add_row(0,   0,   0,   1, 1,   1,   1);
    add_row(359, 255, 0,   1, 1,   1,   1);
    add_row(0,   0,   255, 1, 255, 255, 255);
    add_row(511, 0,   255, 1, 255, 255, 255);
    // Pure primaries and secondaries at each sector start.
    add_row(0,   255, 255, 1, 255, 1,   1);
    add_row(60,  255, 255, 1, 255, 255, 1);
    add_row(120, 255, 255, 1, 1,   255, 1);
    add_row(180, 255, 255, 1, 1,   255, 255);
    add_row(240, 255, 255, 1, 1,   1,   255);
    add_row(300, 255, 255, 1, 255, 1,   255);
    // Hue past 359 wraps to the magenta rule.
    add_row(360, 255, 255, 1, 255, 1,   255);
    // Mid-sector and boundary hues, checked by prediction.
    add_row(30,  255, 255, 0);
    add_row(59,  255, 255, 0);
    add_row(90,  128, 200, 0);
    add_row(150, 1,   254, 0);
    add_row(210, 254, 1,   0);
    add_row(270, 200, 100, 0);
    add_row(330, 77,  255, 0);
    add_row(359, 255, 255, 0);
    add_row(419, 255, 128, 0);
    add_row(420, 100, 255, 0);
    add_row(479, 255, 255, 0);
    add_row(480, 255, 255, 0);
    add_row(511, 255, 255, 0);
    add_row(256, 170, 85,  0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i])
      send_pixel(plan[i].px, pick_gap(), plan[i].typed, plan[i].rgb);

    // Hold off the sender until the directed words have all come out.
    drain_pipe();

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i == BACKPRESSURE_AT) hold_req = 1'b1;   // sender keeps offering meanwhile
      if (i == DRAIN_AT) drain_pipe();
      steady = (i >= STEADY_FROM && i < STEADY_TO);
      gap    = steady ? 0 : pick_gap();
      send_pixel(pick_pixel(), gap, 1'b0, none);
    end
    steady = 1'b0;

    drain_pipe();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Converted %0d pixels (%0d with hue above 359), %0d words checked, %0d errors.",
             pixels_sent, wide_hues, pixels_checked, errors);
    $display("Covered every sector, black and full-scale levels, a long output hold and drains.");
    if (errors == 0)
      $display("tb_hsv_to_rgb_gamma: done, clean");
    else
      $display("tb_hsv_to_rgb_gamma: done, errors");
    $finish;
  end

endmodule
